FILE: rtl/core/mcc_pkg.sv
// shared types, widths and calendar constants for the minute calendar clock
package mcc_pkg;

    localparam int MINUTE_W  = 6;
    localparam int HOUR_W    = 5;
    localparam int DOY_W     = 9;
    localparam int YEAR_W    = 7;
    localparam int WEEKDAY_W = 3;
    localparam int MONTH_W   = 4;
    localparam int DATE_W    = 5;
    localparam int FLAGS_W   = 5;

    // bit positions in the known flags
    localparam int FLAG_MINUTE  = 0;
    localparam int FLAG_HOUR    = 1;
    localparam int FLAG_DOY     = 2;
    localparam int FLAG_YEAR    = 3;
    localparam int FLAG_WEEKDAY = 4;

    localparam logic [MINUTE_W:0]    MINUTES_PER_HOUR = 7'd60;
    localparam logic [HOUR_W:0]      HOURS_PER_DAY    = 6'd24;
    localparam logic [WEEKDAY_W:0]   DAYS_PER_WEEK    = 4'd7;
    localparam logic [YEAR_W:0]      YEARS_PER_CENT   = 8'd100;
    localparam logic [DOY_W:0]       DAYS_PLAIN_YEAR  = 10'd365;
    localparam logic [DOY_W:0]       DAYS_LEAP_YEAR   = 10'd366;

    localparam logic          CMD_TICK = 1'b0;
    localparam logic          CMD_LOAD = 1'b1;

    // last day of year of each month in a plain year, entry 0 is the day before january
    localparam logic [DOY_W-1:0] MONTH_END [0:12] = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
        9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365
    };

    typedef struct packed {
        logic [MINUTE_W-1:0]  minute;
        logic [HOUR_W-1:0]    hour;
        logic [DOY_W-1:0]     doy;
        logic [YEAR_W-1:0]    year;
        logic [WEEKDAY_W-1:0] weekday;
        logic [FLAGS_W-1:0]   known;
    } t_cal_state;

    typedef struct packed {
        logic [MONTH_W-1:0] month;
        logic [DATE_W-1:0]  date;
    } t_month_date;

    function automatic logic is_leap(input t_cal_state s);
        is_leap = s.known[FLAG_YEAR] && (s.year[1:0] == 2'b00);
    endfunction

endpackage

FILE: rtl/core/mcc_month_date.sv
// month and day of month derived from the day of year
module mcc_month_date
    import mcc_pkg::*;
(
    input  t_cal_state  i_state,
    output t_month_date o_md
);

    logic             leap;
    logic [DOY_W:0]   year_len;
    logic             in_year;
    logic [DOY_W-1:0] end_cur;
    logic [DOY_W-1:0] end_prev;
    logic [DOY_W-1:0] diff;

    always_comb begin
        leap     = is_leap(i_state);
        year_len = leap ? DAYS_LEAP_YEAR : DAYS_PLAIN_YEAR;
        in_year  = i_state.known[FLAG_YEAR] && i_state.known[FLAG_DOY]
                   && (i_state.doy != '0) && ({1'b0, i_state.doy} <= year_len);
        o_md     = '0;
        diff     = '0;
        // scan from december down so the lowest month that holds the day wins
        for (int m = 12; m >= 1; m--) begin
            end_cur  = MONTH_END[m] + ((leap && m >= 2) ? 9'd1 : 9'd0);
            end_prev = MONTH_END[m-1] + ((leap && m >= 3) ? 9'd1 : 9'd0);
            if (i_state.doy <= end_cur) begin
                o_md.month = MONTH_W'(m);
                diff       = i_state.doy - end_prev;
                o_md.date  = diff[DATE_W-1:0];
            end
        end
        if (!in_year) begin
            o_md = '0;
        end
    end

endmodule

FILE: rtl/core/minute_calendar_clock_core.sv
// minute calendar clock top level: input stage, calendar update and result register
//
//  channel | valid   | stall   | payload
//  --------+---------+---------+------------------------------------------------
//  in      | i_valid | o_stall | i_cmd, i_*_in, i_*_known_in
//  out     | o_valid | i_stall | o_*_out, o_*_known, o_month_out, o_date_out
//
// one word per cycle while the output is not stalled; a word lands in the input register when it is
// accepted, and the calendar update then loads the result register from it once the output can take
// a word; the result is offered from the result register.
// synchronous active-low reset clears the calendar to day 1 with every field unknown.
// when the output is stalled the input register still takes one more word, then o_stall rises.
module minute_calendar_clock_core
    import mcc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic                 i_cmd,
    input  logic [MINUTE_W-1:0]  i_minute_in,
    input  logic                 i_minute_known_in,
    input  logic [HOUR_W-1:0]    i_hour_in,
    input  logic                 i_hour_known_in,
    input  logic [DOY_W-1:0]     i_doy_in,
    input  logic                 i_doy_known_in,
    input  logic [YEAR_W-1:0]    i_year_in,
    input  logic                 i_year_known_in,
    input  logic [WEEKDAY_W-1:0] i_weekday_in,
    input  logic                 i_weekday_known_in,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [MINUTE_W-1:0]  o_minute_out,
    output logic                 o_minute_known,
    output logic [HOUR_W-1:0]    o_hour_out,
    output logic                 o_hour_known,
    output logic [DOY_W-1:0]     o_doy_out,
    output logic                 o_doy_known,
    output logic [YEAR_W-1:0]    o_year_out,
    output logic                 o_year_known,
    output logic [WEEKDAY_W-1:0] o_weekday_out,
    output logic                 o_weekday_known,
    output logic [MONTH_W-1:0]   o_month_out,
    output logic [DATE_W-1:0]    o_date_out
);

    logic        r_s1_valid;
    logic        r_cmd;
    t_cal_state  r_ld;
    t_cal_state  r_state;
    t_cal_state  n_state;
    t_cal_state  r_out;
    t_month_date r_md;
    t_month_date n_md;
    logic        r_o_valid;

    logic        out_ready;
    logic        s2_fire;
    logic        in_acc;

    logic [MINUTE_W:0]  min_inc;
    logic [HOUR_W:0]    hour_inc;
    logic [DOY_W:0]     doy_inc;
    logic [YEAR_W:0]    year_inc;
    logic [WEEKDAY_W:0] wday_inc;
    logic [DOY_W:0]     year_len;
    logic               hour_carry;
    logic               day_carry;

    assign out_ready = !r_o_valid || !i_stall;
    assign s2_fire   = r_s1_valid && out_ready;
    assign o_stall   = r_s1_valid && !out_ready;
    assign in_acc    = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s2_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cmd        <= i_cmd;
            r_ld.minute  <= i_minute_in;
            r_ld.hour    <= i_hour_in;
            r_ld.doy     <= i_doy_in;
            r_ld.year    <= i_year_in;
            r_ld.weekday <= i_weekday_in;
            r_ld.known   <= {i_weekday_known_in, i_year_known_in, i_doy_known_in,
                             i_hour_known_in, i_minute_known_in};
        end
    end

    // minute tick with carries through hour, day, weekday and year, or a load of the input word
    always_comb begin
        min_inc    = {1'b0, r_state.minute} + 7'd1;
        hour_inc   = {1'b0, r_state.hour} + 6'd1;
        doy_inc    = {1'b0, r_state.doy} + 10'd1;
        year_inc   = {1'b0, r_state.year} + 8'd1;
        wday_inc   = {1'b0, r_state.weekday} + 4'd1;
        year_len   = is_leap(r_state) ? DAYS_LEAP_YEAR : DAYS_PLAIN_YEAR;
        hour_carry = 1'b0;
        day_carry  = 1'b0;
        n_state    = r_state;
        if (r_cmd == CMD_LOAD) begin
            n_state = r_ld;
        end else if (r_state.known[FLAG_MINUTE]) begin
            if (min_inc < MINUTES_PER_HOUR) begin
                n_state.minute = min_inc[MINUTE_W-1:0];
            end else begin
                n_state.minute = '0;
                hour_carry     = r_state.known[FLAG_HOUR];
            end
            if (hour_carry) begin
                if (hour_inc < HOURS_PER_DAY) begin
                    n_state.hour = hour_inc[HOUR_W-1:0];
                end else begin
                    n_state.hour = '0;
                    day_carry    = 1'b1;
                end
            end
            if (day_carry) begin
                if (r_state.known[FLAG_WEEKDAY]) begin
                    n_state.weekday = (wday_inc >= DAYS_PER_WEEK) ? '0
                                      : wday_inc[WEEKDAY_W-1:0];
                end
                if (r_state.known[FLAG_DOY]) begin
                    if (doy_inc > year_len) begin
                        n_state.doy = 9'd1;
                        if (r_state.known[FLAG_YEAR]) begin
                            n_state.year = (year_inc >= YEARS_PER_CENT) ? '0
                                           : year_inc[YEAR_W-1:0];
                        end
                    end else begin
                        n_state.doy = doy_inc[DOY_W-1:0];
                    end
                end
            end
        end
    end

    mcc_month_date u_month_date (
        .i_state (n_state),
        .o_md    (n_md)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= '{minute: '0, hour: '0, doy: DOY_W'(1), year: '0,
                           weekday: '0, known: '0};
            r_o_valid <= 1'b0;
        end else begin
            if (s2_fire) begin
                r_state   <= n_state;
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_fire) begin
            r_out <= n_state;
            r_md  <= n_md;
        end
    end

    assign o_valid         = r_o_valid;
    assign o_minute_known  = r_out.known[FLAG_MINUTE];
    assign o_hour_known    = r_out.known[FLAG_HOUR];
    assign o_doy_known     = r_out.known[FLAG_DOY];
    assign o_year_known    = r_out.known[FLAG_YEAR];
    assign o_weekday_known = r_out.known[FLAG_WEEKDAY];
    // unknown fields read as zero
    assign o_minute_out    = o_minute_known  ? r_out.minute  : '0;
    assign o_hour_out      = o_hour_known    ? r_out.hour    : '0;
    assign o_doy_out       = o_doy_known     ? r_out.doy     : '0;
    assign o_year_out      = o_year_known    ? r_out.year    : '0;
    assign o_weekday_out   = o_weekday_known ? r_out.weekday : '0;
    assign o_month_out     = r_md.month;
    assign o_date_out      = r_md.date;

endmodule

FILE: rtl/core/mcc_checker.sv
// port-level checks for the minute calendar clock, bound to the top level
module mcc_checker
    import mcc_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_valid,
    input logic                 o_stall,
    input logic                 i_cmd,
    input logic [MINUTE_W-1:0]  i_minute_in,
    input logic                 i_minute_known_in,
    input logic [HOUR_W-1:0]    i_hour_in,
    input logic                 i_hour_known_in,
    input logic [DOY_W-1:0]     i_doy_in,
    input logic                 i_doy_known_in,
    input logic [YEAR_W-1:0]    i_year_in,
    input logic                 i_year_known_in,
    input logic [WEEKDAY_W-1:0] i_weekday_in,
    input logic                 i_weekday_known_in,
    input logic                 o_valid,
    input logic                 i_stall,
    input logic [MINUTE_W-1:0]  o_minute_out,
    input logic                 o_minute_known,
    input logic [HOUR_W-1:0]    o_hour_out,
    input logic                 o_hour_known,
    input logic [DOY_W-1:0]     o_doy_out,
    input logic                 o_doy_known,
    input logic [YEAR_W-1:0]    o_year_out,
    input logic                 o_year_known,
    input logic [WEEKDAY_W-1:0] o_weekday_out,
    input logic                 o_weekday_known,
    input logic [MONTH_W-1:0]   o_month_out,
    input logic [DATE_W-1:0]    o_date_out
);

    // a stalled input word stays
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_stall |=> i_valid && $stable(i_cmd)
            && $stable(i_minute_in) && $stable(i_minute_known_in)
            && $stable(i_hour_in) && $stable(i_hour_known_in)
            && $stable(i_doy_in) && $stable(i_doy_known_in)
            && $stable(i_year_in) && $stable(i_year_known_in)
            && $stable(i_weekday_in) && $stable(i_weekday_known_in))
        else $error("stalled input word changed");

    // a stalled output word keeps its month, date, minute and day of year
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_month_out) && $stable(o_date_out)
            && $stable(o_minute_out) && $stable(o_doy_out))
        else $error("stalled output word changed");

    a_unknown_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_minute_known || o_minute_out == '0)
            && (o_hour_known || o_hour_out == '0)
            && (o_doy_known || o_doy_out == '0)
            && (o_year_known || o_year_out == '0)
            && (o_weekday_known || o_weekday_out == '0))
        else $error("unknown field not shown as zero");

    a_md_unknown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (!o_year_known || !o_doy_known) |-> o_month_out == '0 && o_date_out == '0)
        else $error("month or date shown without known year and day");

    // month and date are zero together, and month is at most 12
    a_md_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_month_out == '0) == (o_date_out == '0) && o_month_out <= 4'd12)
        else $error("month and date disagree");

endmodule

bind minute_calendar_clock_core mcc_checker u_mcc_checker (.*);
